[rtl/lso_pkg.sv]
// ----------------------------------------------------------------------------
// lso_pkg: shared types and constants for the sticker overlay compositor
// Opcodes, status codes, table sizes and the pixel word layout.
// ----------------------------------------------------------------------------
package lso_pkg;

    localparam int MAX_LAYERS  = 8;
    localparam int IMAGE_SLOTS = 4;
    localparam int IMAGE_SIDE  = 64;

    localparam int LAYER_W  = $clog2(MAX_LAYERS);
    localparam int COUNT_W  = $clog2(MAX_LAYERS + 1);
    localparam int SLOT_W   = 2;
    localparam int SIDE_W   = $clog2(IMAGE_SIDE);
    localparam int SIZE_W   = 7;
    localparam int PIX_W    = 33;
    localparam int ADDR_W   = SLOT_W + 2 * SIDE_W;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_SIZE    = 3'd1,
        OP_ADD     = 3'd2,
        OP_MOVE    = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_QUERY   = 3'd5,
        OP_COMPOSE = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] CFG_BASE_W = 2'd0;
    localparam logic [1:0] CFG_BASE_H = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    localparam logic [PIX_W-1:0] WHITE_PX = {9'd0, 8'd0, 8'd255, 8'd255};

    // one pixel store port request
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } mem_req_t;

endpackage

[rtl/layered_sticker_overlay_compositor.sv]
// Query and compose walk every layer entry; compose also reads a pixel
// for each covering layer; remove shifts down the entries above its layer.
// One layer entry is visited per cycle by a single shared compare/add unit,
// except while compose waits on a pixel read for a covering layer.
// One item at a time: s_ready is low until the result beat is taken.
// Reset (aresetn low, synchronous) empties the layer table and zeroes sizes.
// ----------------------------------------------------------------------------
// layered_sticker_overlay_compositor: sprite overlay engine top level
// Layer table, image size table, sequencer and pixel store.
// ----------------------------------------------------------------------------
module layered_sticker_overlay_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [1:0]  s_slot,
    input  logic [2:0]  s_layer,
    input  logic [11:0] s_pos_x,
    input  logic [11:0] s_pos_y,
    input  logic [6:0]  s_size_w,
    input  logic [6:0]  s_size_h,
    input  logic [8:0]  s_hue,
    input  logic [7:0]  s_sat,
    input  logic [7:0]  s_lum,
    input  logic [7:0]  s_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_new_layer,
    output logic [12:0] m_canvas_w,
    output logic [12:0] m_canvas_h,
    output logic [8:0]  m_out_hue,
    output logic [7:0]  m_out_sat,
    output logic [7:0]  m_out_lum,
    output logic [7:0]  m_out_alpha
);

    localparam int LW = lso_pkg::LAYER_W;
    localparam int CW = lso_pkg::COUNT_W;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_READ, S_DONE} state_t;

    state_t state_reg;
    logic [12:0] base_w_reg, base_h_reg;
    logic [3:0]  limit_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]  lslot_reg [lso_pkg::MAX_LAYERS];
    logic [11:0] lx_reg    [lso_pkg::MAX_LAYERS];
    logic [11:0] ly_reg    [lso_pkg::MAX_LAYERS];
    logic [6:0]  iw_reg    [lso_pkg::IMAGE_SLOTS];
    logic [6:0]  ih_reg    [lso_pkg::IMAGE_SLOTS];

    lso_pkg::op_t op_reg;
    logic [1:0]  slot_reg;
    logic [2:0]  layer_reg;
    logic [11:0] px_reg, py_reg;
    logic [6:0]  sw_reg, sh_reg;
    logic [lso_pkg::PIX_W-1:0] pix_reg, cur_reg;
    logic [CW-1:0] idx_reg;
    logic [12:0] cw_reg, ch_reg;
    logic [1:0]  status_reg;
    logic [2:0]  newl_reg;

    lso_pkg::mem_req_t req;
    logic [lso_pkg::PIX_W-1:0] rdata;

    lso_pixel_ram u_ram (.aclk(aclk), .req(req), .rdata(rdata));

    // effective limit
    logic [CW-1:0] eff_lim, cfg_lim;
    always_comb begin
        eff_lim = (limit_reg > 4'(lso_pkg::MAX_LAYERS)) ? CW'(lso_pkg::MAX_LAYERS)
                                                        : CW'(limit_reg);
        cfg_lim = (cfg_data[3:0] > 4'(lso_pkg::MAX_LAYERS)) ? CW'(lso_pkg::MAX_LAYERS)
                                                            : CW'(cfg_data[3:0]);
    end

    // shared unit: per-layer offsets and extents for the entry at idx_reg
    logic [LW-1:0] il;
    logic [1:0]    cs;
    logic [6:0]    cwid, chgt;
    logic [12:0]   ex, ey;
    logic [11:0]   dx, dy;
    logic          hit;
    always_comb begin
        il   = idx_reg[LW-1:0];
        cs   = lslot_reg[il];
        cwid = iw_reg[cs];
        chgt = ih_reg[cs];
        ex   = 13'(lx_reg[il]) + 13'(cwid);
        ey   = 13'(ly_reg[il]) + 13'(chgt);
        dx   = px_reg - lx_reg[il];
        dy   = py_reg - ly_reg[il];
        hit  = (px_reg >= lx_reg[il]) && (py_reg >= ly_reg[il]) &&
               (dx < 12'(cwid)) && (dy < 12'(chgt));
    end

    always_comb begin
        req.wr    = 1'b0;
        req.addr  = {cs, dy[lso_pkg::SIDE_W-1:0], dx[lso_pkg::SIDE_W-1:0]};
        req.wdata = pix_reg;
        if (state_reg == S_EXEC && op_reg == lso_pkg::OP_LOAD) begin
            req.addr = {slot_reg, py_reg[lso_pkg::SIDE_W-1:0], px_reg[lso_pkg::SIDE_W-1:0]};
            req.wr   = (px_reg < 12'(lso_pkg::IMAGE_SIDE)) &&
                       (py_reg < 12'(lso_pkg::IMAGE_SIDE));
        end
    end

    // a register write takes the idle slot first
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_DONE);
    assign m_status    = status_reg;
    assign m_new_layer = newl_reg;
    assign m_canvas_w  = cw_reg;
    assign m_canvas_h  = ch_reg;
    assign m_out_hue   = cur_reg[32:24];
    assign m_out_sat   = cur_reg[23:16];
    assign m_out_lum   = cur_reg[15:8];
    assign m_out_alpha = cur_reg[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            base_w_reg <= 13'd640;
            base_h_reg <= 13'd480;
            limit_reg  <= 4'd8;
            count_reg  <= '0;
            for (int i = 0; i < lso_pkg::IMAGE_SLOTS; i++) begin
                iw_reg[i] <= '0;
                ih_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            lso_pkg::CFG_BASE_W: base_w_reg <= cfg_data;
                            lso_pkg::CFG_BASE_H: base_h_reg <= cfg_data;
                            lso_pkg::CFG_LIMIT: begin
                                limit_reg <= cfg_data[3:0];
                                if (count_reg > cfg_lim) count_reg <= cfg_lim;
                            end
                            default: ;
                        endcase
                    end else if (s_valid) begin
                        op_reg    <= lso_pkg::op_t'(s_op);
                        slot_reg  <= s_slot;
                        layer_reg <= s_layer;
                        px_reg    <= s_pos_x;
                        py_reg    <= s_pos_y;
                        sw_reg    <= s_size_w;
                        sh_reg    <= s_size_h;
                        pix_reg   <= {s_hue, s_sat, s_lum, s_alpha};
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg <= lso_pkg::ST_OK;
                    newl_reg   <= '0;
                    cw_reg     <= '0;
                    ch_reg     <= '0;
                    cur_reg    <= '0;
                    state_reg  <= S_DONE;
                    case (op_reg)
                        lso_pkg::OP_SIZE: begin
                            iw_reg[slot_reg] <= (sw_reg > 7'(lso_pkg::IMAGE_SIDE))
                                                ? 7'(lso_pkg::IMAGE_SIDE) : sw_reg;
                            ih_reg[slot_reg] <= (sh_reg > 7'(lso_pkg::IMAGE_SIDE))
                                                ? 7'(lso_pkg::IMAGE_SIDE) : sh_reg;
                        end
                        lso_pkg::OP_ADD: begin
                            if (count_reg >= eff_lim) begin
                                status_reg <= lso_pkg::ST_FULL;
                            end else begin
                                lslot_reg[count_reg[LW-1:0]] <= slot_reg;
                                lx_reg[count_reg[LW-1:0]]    <= px_reg;
                                ly_reg[count_reg[LW-1:0]]    <= py_reg;
                                newl_reg  <= 3'(count_reg);
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        lso_pkg::OP_MOVE: begin
                            if (CW'(layer_reg) >= count_reg) begin
                                status_reg <= lso_pkg::ST_BAD;
                            end else begin
                                lx_reg[layer_reg[LW-1:0]] <= px_reg;
                                ly_reg[layer_reg[LW-1:0]] <= py_reg;
                            end
                        end
                        lso_pkg::OP_REMOVE: begin
                            if (CW'(layer_reg) >= count_reg) begin
                                status_reg <= lso_pkg::ST_BAD;
                            end else begin
                                idx_reg   <= CW'(layer_reg);
                                state_reg <= S_WALK;
                            end
                        end
                        lso_pkg::OP_QUERY: begin
                            cw_reg    <= base_w_reg;
                            ch_reg    <= base_h_reg;
                            idx_reg   <= '0;
                            state_reg <= S_WALK;
                        end
                        lso_pkg::OP_COMPOSE: begin
                            cur_reg <= (13'(px_reg) >= base_w_reg || 13'(py_reg) >= base_h_reg)
                                       ? lso_pkg::WHITE_PX : pix_reg;
                            idx_reg   <= '0;
                            state_reg <= S_WALK;
                        end
                        default: ;
                    endcase
                end
                S_WALK: begin
                    if (op_reg == lso_pkg::OP_REMOVE) begin
                        if (idx_reg + 1'b1 < count_reg) begin
                            lslot_reg[il] <= lslot_reg[LW'(idx_reg + 1'b1)];
                            lx_reg[il]    <= lx_reg[LW'(idx_reg + 1'b1)];
                            ly_reg[il]    <= ly_reg[LW'(idx_reg + 1'b1)];
                            idx_reg       <= idx_reg + 1'b1;
                        end else begin
                            count_reg <= count_reg - 1'b1;
                            state_reg <= S_DONE;
                        end
                    end else if (idx_reg >= count_reg) begin
                        state_reg <= S_DONE;
                    end else if (op_reg == lso_pkg::OP_QUERY) begin
                        if (ex > cw_reg) cw_reg <= ex;
                        if (ey > ch_reg) ch_reg <= ey;
                        idx_reg <= idx_reg + 1'b1;
                    end else if (hit) begin
                        // address is on the RAM this cycle; data next cycle
                        state_reg <= S_READ;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_READ: begin
                    if (rdata[7:0] != 8'd0) cur_reg <= rdata;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_WALK;
                end
                S_DONE: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/lso_pixel_ram.sv]
// ----------------------------------------------------------------------------
// lso_pixel_ram: sticker pixel store
// Single port, registered read data.
// ----------------------------------------------------------------------------
module lso_pixel_ram (
    input  logic                     aclk,
    input  lso_pkg::mem_req_t        req,
    output logic [lso_pkg::PIX_W-1:0] rdata
);

    logic [lso_pkg::PIX_W-1:0] mem [2**lso_pkg::ADDR_W];

    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

[rtl/lso_checker.sv]
// ----------------------------------------------------------------------------
// lso_port_checks: port-level checks for the overlay compositor
// Watches handshakes and result codes on the top level.
// ----------------------------------------------------------------------------
module lso_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [2:0] m_new_layer
);

    // one item in flight: no accept while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted with result pending");

    // a result needs an accepted beat before it
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");

    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == lso_pkg::ST_OK) || (m_status == lso_pkg::ST_FULL) ||
                     (m_status == lso_pkg::ST_BAD)))
        else $error("bad status code");

    a_newl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != lso_pkg::ST_OK) |-> (m_new_layer == 3'd0))
        else $error("new_layer set on failure");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result dropped while stalled");

endmodule

bind layered_sticker_overlay_compositor lso_port_checks u_lso_port_checks (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_new_layer(m_new_layer)
);

[tb/lso_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lso_checker: scoreboard for the sticker overlay compositor
// Watches the config, input and result channels, keeps a shadow copy of the
// layer table, image sizes and pixel store, and checks every result beat.
// ----------------------------------------------------------------------------
module lso_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [1:0]  s_slot,
    input  logic [2:0]  s_layer,
    input  logic [11:0] s_pos_x,
    input  logic [11:0] s_pos_y,
    input  logic [6:0]  s_size_w,
    input  logic [6:0]  s_size_h,
    input  logic [8:0]  s_hue,
    input  logic [7:0]  s_sat,
    input  logic [7:0]  s_lum,
    input  logic [7:0]  s_alpha,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [2:0]  m_new_layer,
    input  logic [12:0] m_canvas_w,
    input  logic [12:0] m_canvas_h,
    input  logic [8:0]  m_out_hue,
    input  logic [7:0]  m_out_sat,
    input  logic [7:0]  m_out_lum,
    input  logic [7:0]  m_out_alpha,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  new_layer;
        logic [12:0] canvas_w;
        logic [12:0] canvas_h;
        logic [8:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  lum;
        logic [7:0]  alpha;
    } overlay_res_t;

    logic [12:0] base_w, base_h;
    logic [3:0]  limit_reg;
    logic [1:0]  lyr_slot [lso_pkg::MAX_LAYERS];
    logic [11:0] lyr_x [lso_pkg::MAX_LAYERS];
    logic [11:0] lyr_y [lso_pkg::MAX_LAYERS];
    int          lyr_count;
    int          img_w [lso_pkg::IMAGE_SLOTS];
    int          img_h [lso_pkg::IMAGE_SLOTS];
    logic [lso_pkg::PIX_W-1:0] pix_mem [lso_pkg::IMAGE_SLOTS*lso_pkg::IMAGE_SIDE*
                                        lso_pkg::IMAGE_SIDE];
    overlay_res_t expected_q [$];

    function automatic int eff_limit();
        return (int'(limit_reg) < lso_pkg::MAX_LAYERS) ? int'(limit_reg)
                                                       : lso_pkg::MAX_LAYERS;
    endfunction

    // applies one input beat to the shadow state and returns its result
    function automatic overlay_res_t overlay_step();
        overlay_res_t r;
        logic [lso_pkg::PIX_W-1:0] cur, sp;
        int px, py, lx, ly, cw, ch, s, sl, lyr, side;
        r = '0;
        px = int'(s_pos_x);
        py = int'(s_pos_y);
        sl = int'(s_slot);
        lyr = int'(s_layer);
        side = lso_pkg::IMAGE_SIDE;
        case (lso_pkg::op_t'(s_op))
            lso_pkg::OP_LOAD: begin
                if (px < side && py < side)
                    pix_mem[(sl*side + py)*side + px] = {s_hue, s_sat, s_lum, s_alpha};
            end
            lso_pkg::OP_SIZE: begin
                img_w[sl] = (int'(s_size_w) < side) ? int'(s_size_w) : side;
                img_h[sl] = (int'(s_size_h) < side) ? int'(s_size_h) : side;
            end
            lso_pkg::OP_ADD: begin
                if (lyr_count >= eff_limit()) begin
                    r.status = lso_pkg::ST_FULL;
                end else begin
                    lyr_slot[lyr_count] = s_slot;
                    lyr_x[lyr_count] = s_pos_x;
                    lyr_y[lyr_count] = s_pos_y;
                    r.new_layer = lyr_count[2:0];
                    lyr_count++;
                end
            end
            lso_pkg::OP_MOVE: begin
                if (lyr >= lyr_count) begin
                    r.status = lso_pkg::ST_BAD;
                end else begin
                    lyr_x[lyr] = s_pos_x;
                    lyr_y[lyr] = s_pos_y;
                end
            end
            lso_pkg::OP_REMOVE: begin
                if (lyr >= lyr_count) begin
                    r.status = lso_pkg::ST_BAD;
                end else begin
                    for (int i = lyr; i + 1 < lyr_count; i++) begin
                        lyr_slot[i] = lyr_slot[i+1];
                        lyr_x[i] = lyr_x[i+1];
                        lyr_y[i] = lyr_y[i+1];
                    end
                    lyr_count--;
                end
            end
            lso_pkg::OP_QUERY: begin
                cw = int'(base_w);
                ch = int'(base_h);
                for (int i = 0; i < lyr_count; i++) begin
                    lx = int'(lyr_x[i]) + img_w[lyr_slot[i]];
                    ly = int'(lyr_y[i]) + img_h[lyr_slot[i]];
                    if (lx > cw) cw = lx;
                    if (ly > ch) ch = ly;
                end
                r.canvas_w = cw[12:0];
                r.canvas_h = ch[12:0];
            end
            lso_pkg::OP_COMPOSE: begin
                if (px >= int'(base_w) || py >= int'(base_h))
                    cur = lso_pkg::WHITE_PX;
                else
                    cur = {s_hue, s_sat, s_lum, s_alpha};
                for (int i = 0; i < lyr_count; i++) begin
                    s = int'(lyr_slot[i]);
                    lx = int'(lyr_x[i]);
                    ly = int'(lyr_y[i]);
                    if (px >= lx && py >= ly && px - lx < img_w[s] && py - ly < img_h[s]) begin
                        sp = pix_mem[(s*side + py - ly)*side + px - lx];
                        if (sp[7:0] != 8'd0) cur = sp;
                    end
                end
                {r.hue, r.sat, r.lum, r.alpha} = cur;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            errors++;
        end
    endtask

    initial begin
        errors = 0;
        foreach (pix_mem[i]) pix_mem[i] = '0;
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        overlay_res_t e;
        if (!aresetn) begin
            base_w = 13'd640;
            base_h = 13'd480;
            limit_reg = 4'd8;
            lyr_count = 0;
            foreach (img_w[i]) begin
                img_w[i] = 0;
                img_h[i] = 0;
            end
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lso_pkg::CFG_BASE_W: base_w = cfg_data;
                    lso_pkg::CFG_BASE_H: base_h = cfg_data;
                    lso_pkg::CFG_LIMIT: begin
                        limit_reg = cfg_data[3:0];
                        if (lyr_count > eff_limit()) lyr_count = eff_limit();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("status", int'(e.status), int'(m_status));
                    check_field("new_layer", int'(e.new_layer), int'(m_new_layer));
                    check_field("canvas_w", int'(e.canvas_w), int'(m_canvas_w));
                    check_field("canvas_h", int'(e.canvas_h), int'(m_canvas_h));
                    check_field("out_hue", int'(e.hue), int'(m_out_hue));
                    check_field("out_sat", int'(e.sat), int'(m_out_sat));
                    check_field("out_lum", int'(e.lum), int'(m_out_lum));
                    check_field("out_alpha", int'(e.alpha), int'(m_out_alpha));
                end
            end
            if (s_valid && s_ready) expected_q.push_back(overlay_step());
        end
    end

endmodule

[tb/layered_sticker_overlay_compositor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layered_sticker_overlay_compositor_tb: top-level testbench
// Directed then randomised traffic over several register settings; results
// are checked by lso_checker, which reports its error count here.
// ----------------------------------------------------------------------------
module layered_sticker_overlay_compositor_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [1:0]  s_slot = '0;
    logic [2:0]  s_layer = '0;
    logic [11:0] s_pos_x = '0;
    logic [11:0] s_pos_y = '0;
    logic [6:0]  s_size_w = '0;
    logic [6:0]  s_size_h = '0;
    logic [8:0]  s_hue = '0;
    logic [7:0]  s_sat = '0;
    logic [7:0]  s_lum = '0;
    logic [7:0]  s_alpha = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_new_layer;
    logic [12:0] m_canvas_w, m_canvas_h;
    logic [8:0]  m_out_hue;
    logic [7:0]  m_out_sat, m_out_lum, m_out_alpha;

    int errors, pending;
    int items_sent = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #4 aclk = ~aclk;

    layered_sticker_overlay_compositor u_top (.*);

    lso_checker u_checker (.*);

    // receiver: random back-pressure plus one long hold-off
    initial begin
        forever @(negedge aclk) begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= aresetn && (calm || $urandom_range(99) >= 21);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic put_item(lso_pkg::op_t op, int slot, int layer, int x, int y, int w, int h,
                            int hue, int sat, int lum, int alpha);
        if (!calm && $urandom_range(99) < 21) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_slot <= 2'(slot);
        s_layer <= 3'(layer);
        s_pos_x <= 12'(x);
        s_pos_y <= 12'(y);
        s_size_w <= 7'(w);
        s_size_h <= 7'(h);
        s_hue <= 9'(hue);
        s_sat <= 8'(sat);
        s_lum <= 8'(lum);
        s_alpha <= 8'(alpha);
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic put_pixel(int slot, int x, int y);
        put_item(lso_pkg::OP_LOAD, slot, $urandom_range(7), x, y, 0, 0, $urandom_range(359),
                 $urandom_range(255), $urandom_range(255),
                 ($urandom_range(3) == 0) ? 0 : $urandom_range(255));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 13'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // load every pixel of a w x h image before its size goes live
    task automatic load_image(int slot, int w, int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) put_pixel(slot, x, y);
        put_item(lso_pkg::OP_SIZE, slot, 0, $urandom_range(4095), 0, w, h, 0, 0, 0, 0);
    endtask

    function automatic int near_pos();
        return ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(80);
    endfunction

    task automatic random_item();
        int k, slot, w, h;
        k = $urandom_range(99);
        slot = $urandom_range(3);
        if (k < 12) begin
            w = $urandom_range(6);
            h = $urandom_range(6);
            load_image(slot, w, h);
        end else if (k < 14) begin
            put_item(lso_pkg::OP_LOAD, slot, 0, $urandom_range(4095),
                     $urandom_range(64, 4095), 0, 0, $urandom_range(359),
                     $urandom_range(255), 255, 255);
        end else if (k < 30) begin
            put_item(lso_pkg::OP_ADD, slot, $urandom_range(7), near_pos(), near_pos(),
                     0, 0, 0, 0, 0, 0);
        end else if (k < 40) begin
            put_item(lso_pkg::OP_MOVE, slot, $urandom_range(7), near_pos(), near_pos(),
                     0, 0, 0, 0, 0, 0);
        end else if (k < 50) begin
            put_item(lso_pkg::OP_REMOVE, slot, $urandom_range(7), 0, 0, 0, 0, 0, 0, 0, 0);
        end else if (k < 57) begin
            put_item(lso_pkg::OP_QUERY, slot, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        end else if (k < 97) begin
            put_item(lso_pkg::OP_COMPOSE, slot, 0, near_pos(), near_pos(), 0, 0,
                     $urandom_range(359), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255));
        end else begin
            put_item(lso_pkg::OP_NONE, slot, $urandom_range(7), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(127), $urandom_range(127),
                     $urandom_range(359), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255));
        end
    endtask

    task automatic random_phase(int n);
        int goal;
        goal = items_sent + n;
        while (items_sent < goal) random_item();
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        load_image(0, 2, 2);
        put_item(lso_pkg::OP_LOAD, 0, 0, 4095, 4095, 0, 0, 359, 255, 255, 255);
        put_item(lso_pkg::OP_ADD, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_ADD, 1, 0, 4095, 4095, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 1, 1, 0, 0, 280, 170, 85, 0);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 2, 2, 0, 0, 359, 255, 0, 255);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0, 255, 1);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 700, 0, 0, 0, 100, 100, 100, 100);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 4095, 4095, 0, 0, 1, 2, 3, 4);
        put_item(lso_pkg::OP_MOVE, 0, 5, 7, 7, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_COMPOSE, 0, 0, 1, 1, 0, 0, 5, 6, 7, 8);
        put_item(lso_pkg::OP_REMOVE, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // oversize slot, checked by query only, then shrunk away again
        put_item(lso_pkg::OP_SIZE, 3, 0, 0, 0, 127, 100, 0, 0, 0, 0);
        put_item(lso_pkg::OP_ADD, 3, 0, 4000, 4000, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_REMOVE, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_SIZE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        put_item(lso_pkg::OP_NONE, 3, 7, 4095, 4095, 127, 127, 511, 255, 255, 255);
        drain();

        random_phase(110);

        write_reg(lso_pkg::CFG_BASE_W, 4096);
        write_reg(lso_pkg::CFG_BASE_H, 4096);
        write_reg(lso_pkg::CFG_LIMIT, 15);
        hold_req = 1'b1;
        random_phase(110);

        calm = 1'b1;
        write_reg(lso_pkg::CFG_BASE_W, 1);
        write_reg(lso_pkg::CFG_BASE_H, 1);
        write_reg(lso_pkg::CFG_LIMIT, 2);
        random_phase(80);
        calm = 1'b0;

        write_reg(lso_pkg::CFG_LIMIT, 0);
        random_phase(30);

        write_reg(lso_pkg::CFG_BASE_W, 100);
        write_reg(lso_pkg::CFG_BASE_H, 60);
        write_reg(lso_pkg::CFG_LIMIT, 8);
        random_phase(120);

        repeat (20) @(posedge aclk);
        $display("Sent %0d items over five register settings, with idling,", items_sent);
        $display("a long result hold-off and drains between phases.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
